### hdl/bpfm_pkg.sv
// Package for the buffer pool frame manager: request/result structs,
// action and status codes, controller states. No dependencies.
package bpfm_pkg;

    localparam int NUM_FRAMES = 16;
    localparam int FW         = $clog2(NUM_FRAMES);
    localparam int CW         = $clog2(NUM_FRAMES + 1);
    localparam int PIN_W      = 16;
    localparam logic [PIN_W-1:0] PIN_MAX = '1;

    typedef enum logic [2:0] {
        ACT_FETCH  = 3'd0,
        ACT_UNPIN  = 3'd1,
        ACT_NEW    = 3'd2,
        ACT_DELETE = 3'd3,
        ACT_FLUSH  = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_FRAME   = 3'd1,
        ST_NOT_RES    = 3'd2,
        ST_UNPINNED   = 3'd3,
        ST_PINNED     = 3'd4
    } status_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] page_id;
        logic        mark_dirty;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  frame_index;
        logic [31:0] assigned_page;
        logic        zero_fill;
        logic        write_back_valid;
        logic [31:0] write_back_page;
        logic        read_valid;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_LRU,
        S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan_step;
        logic exec;
        logic lru_step;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic lru_busy;
    } sts_t;

endpackage

### hdl/bpfm_ctrl.sv
// Controller state machine for the frame manager.
// Depends on bpfm_pkg.
module bpfm_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output bpfm_pkg::cmd_t cmd,
    input  bpfm_pkg::sts_t sts
);
    import bpfm_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_LRU;
            end
            S_LRU: begin
                cmd.lru_step = 1'b1;
                if (!sts.lru_busy) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

### hdl/bpfm_datapath.sv
// Frame metadata, free stack, LRU list, page-id scan and result register.
// Depends on bpfm_pkg.
module bpfm_datapath (
    input  logic           aclk,
    input  logic           aresetn,
    input  bpfm_pkg::req_t s_req,
    output bpfm_pkg::rsp_t m_rsp,
    input  bpfm_pkg::cmd_t cmd,
    output bpfm_pkg::sts_t sts
);
    import bpfm_pkg::*;

    logic [31:0]      page_mem [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] res_reg;
    logic [NUM_FRAMES-1:0] dirty_reg;
    logic [PIN_W-1:0] pins_reg [NUM_FRAMES];
    logic [FW-1:0]    free_reg [NUM_FRAMES];
    logic [CW-1:0]    free_cnt_reg;
    logic [FW-1:0]    lru_reg [NUM_FRAMES];
    logic [CW-1:0]    lru_cnt_reg;
    logic [31:0]      next_page_reg;

    req_t             req_reg;
    rsp_t             rsp_reg;
    logic [CW-1:0]    scan_reg;
    logic             hit_reg;
    logic [FW-1:0]    hit_idx_reg;
    // LRU removal sweep: compact out one frame, one entry per cycle
    logic             rm_act_reg;
    logic [FW-1:0]    rm_frame_reg;
    logic [CW-1:0]    rm_rd_reg;
    logic [CW-1:0]    rm_wr_reg;

    logic [FW-1:0]    scan_idx;
    logic [31:0]      scan_page;
    assign scan_idx  = scan_reg[FW-1:0];
    assign scan_page = page_mem[scan_idx];

    assign sts.scan_done = (scan_reg == CW'(NUM_FRAMES - 1)) || hit_reg;
    assign sts.lru_busy  = rm_act_reg;
    assign m_rsp         = rsp_reg;

    // frame choice for a miss or new page
    logic          have_free, have_lru, take_ok;
    logic [FW-1:0] take_f;
    logic [CW-1:0] free_top;
    assign free_top  = free_cnt_reg - CW'(1);
    assign have_free = free_cnt_reg != '0;
    assign have_lru  = lru_cnt_reg != '0;
    assign take_ok   = have_free || have_lru;
    assign take_f    = have_free ? free_reg[free_top[FW-1:0]] : lru_reg[0];

    always_ff @(posedge aclk) begin
        rsp_t rsp_next;
        if (!aresetn) begin
            res_reg       <= '0;
            dirty_reg     <= '0;
            free_cnt_reg  <= CW'(NUM_FRAMES);
            lru_cnt_reg   <= '0;
            next_page_reg <= '0;
            rm_act_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            scan_reg      <= '0;
            for (int i = 0; i < NUM_FRAMES; i++) begin
                pins_reg[i] <= '0;
                free_reg[i] <= FW'(i);
            end
        end else begin
            if (cmd.load) begin
                req_reg  <= s_req;
                scan_reg <= '0;
                hit_reg  <= 1'b0;
            end
            if (cmd.scan_step && !hit_reg) begin
                if (res_reg[scan_idx] && scan_page == req_reg.page_id) begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= scan_idx;
                end else if (scan_reg != CW'(NUM_FRAMES - 1)) begin
                    scan_reg <= scan_reg + CW'(1);
                end
            end
            if (cmd.exec) begin
                rsp_next = '0;
                unique case (req_reg.action)
                    ACT_FETCH: begin
                        if (hit_reg) begin
                            if (pins_reg[hit_idx_reg] != PIN_MAX)
                                pins_reg[hit_idx_reg] <= pins_reg[hit_idx_reg] + PIN_W'(1);
                            rsp_next.frame_index = 4'(hit_idx_reg);
                            rm_act_reg   <= 1'b1;
                            rm_frame_reg <= hit_idx_reg;
                            rm_rd_reg    <= '0;
                            rm_wr_reg    <= '0;
                        end else if (!take_ok) begin
                            rsp_next.status = ST_NO_FRAME;
                        end else begin
                            page_mem[take_f]  <= req_reg.page_id;
                            res_reg[take_f]   <= 1'b1;
                            pins_reg[take_f]  <= PIN_W'(1);
                            dirty_reg[take_f] <= 1'b0;
                            rsp_next.frame_index = 4'(take_f);
                            rsp_next.read_valid  = 1'b1;
                        end
                    end
                    ACT_NEW: begin
                        if (!take_ok) begin
                            rsp_next.status = ST_NO_FRAME;
                        end else begin
                            page_mem[take_f]  <= next_page_reg;
                            res_reg[take_f]   <= 1'b1;
                            pins_reg[take_f]  <= PIN_W'(1);
                            dirty_reg[take_f] <= 1'b1;
                            rsp_next.frame_index   = 4'(take_f);
                            rsp_next.assigned_page = next_page_reg;
                            rsp_next.zero_fill     = 1'b1;
                            next_page_reg <= next_page_reg + 32'd1;
                        end
                    end
                    ACT_UNPIN: begin
                        if (!hit_reg) begin
                            rsp_next.status = ST_NOT_RES;
                        end else if (pins_reg[hit_idx_reg] == '0) begin
                            rsp_next.status = ST_UNPINNED;
                        end else begin
                            pins_reg[hit_idx_reg] <= pins_reg[hit_idx_reg] - PIN_W'(1);
                            if (req_reg.mark_dirty) dirty_reg[hit_idx_reg] <= 1'b1;
                            // frame not in list when pinned, so append directly
                            if (pins_reg[hit_idx_reg] == PIN_W'(1)
                                && lru_cnt_reg != CW'(NUM_FRAMES)) begin
                                lru_reg[lru_cnt_reg[FW-1:0]] <= hit_idx_reg;
                                lru_cnt_reg <= lru_cnt_reg + CW'(1);
                            end
                        end
                    end
                    ACT_DELETE: begin
                        if (hit_reg) begin
                            if (pins_reg[hit_idx_reg] != '0) begin
                                rsp_next.status = ST_PINNED;
                            end else begin
                                res_reg[hit_idx_reg]   <= 1'b0;
                                dirty_reg[hit_idx_reg] <= 1'b0;
                                rm_act_reg   <= 1'b1;
                                rm_frame_reg <= hit_idx_reg;
                                rm_rd_reg    <= '0;
                                rm_wr_reg    <= '0;
                                if (free_cnt_reg != CW'(NUM_FRAMES)) begin
                                    free_reg[free_cnt_reg[FW-1:0]] <= hit_idx_reg;
                                    free_cnt_reg <= free_cnt_reg + CW'(1);
                                end
                            end
                        end
                    end
                    ACT_FLUSH: begin
                        if (hit_reg) begin
                            rsp_next.write_back_valid = 1'b1;
                            rsp_next.write_back_page  = req_reg.page_id;
                            dirty_reg[hit_idx_reg]   <= 1'b0;
                        end
                    end
                    default: ;
                endcase
                // victim bookkeeping for a frame taken on miss or new page
                if (((req_reg.action == ACT_FETCH && !hit_reg) || req_reg.action == ACT_NEW)
                    && take_ok) begin
                    if (have_free) begin
                        free_cnt_reg <= free_top;
                    end else begin
                        if (res_reg[take_f] && dirty_reg[take_f]) begin
                            rsp_next.write_back_valid = 1'b1;
                            rsp_next.write_back_page  = page_mem[take_f];
                        end
                        rm_act_reg   <= 1'b1;
                        rm_frame_reg <= take_f;
                        rm_rd_reg    <= '0;
                        rm_wr_reg    <= '0;
                    end
                end
                rsp_reg <= rsp_next;
            end
            if (cmd.lru_step && rm_act_reg) begin
                if (rm_rd_reg >= lru_cnt_reg) begin
                    lru_cnt_reg <= rm_wr_reg;
                    rm_act_reg  <= 1'b0;
                end else begin
                    if (lru_reg[rm_rd_reg[FW-1:0]] != rm_frame_reg) begin
                        lru_reg[rm_wr_reg[FW-1:0]] <= lru_reg[rm_rd_reg[FW-1:0]];
                        rm_wr_reg <= rm_wr_reg + CW'(1);
                    end
                    rm_rd_reg <= rm_rd_reg + CW'(1);
                end
            end
        end
    end

endmodule

### hdl/buffer_pool_frame_manager.sv
// Top level of the buffer pool frame manager: joins controller and datapath.
// Depends on bpfm_pkg, bpfm_ctrl, bpfm_datapath.
//
// One request at a time. Each passes through an accept state, a page-id
// scan (one frame per cycle, stopping in the cycle after the first match),
// an execute state, an LRU pass that runs a compaction sweep over the
// single-port LRU list when a frame leaves it (fetch hit, delete, eviction),
// and a result state. The result is held until m_ready.
module buffer_pool_frame_manager (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  bpfm_pkg::req_t s_req,
    output logic           m_valid,
    input  logic           m_ready,
    output bpfm_pkg::rsp_t m_rsp
);
    import bpfm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequence the request through scan, execute and LRU sweep
    bpfm_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .cmd, .sts
    );

    // hold frame state and build the result
    bpfm_datapath u_dp (
        .aclk, .aresetn, .s_req, .m_rsp, .cmd, .sts
    );

endmodule

### hdl/bpfm_checker.sv
// Port-level checks for the frame manager, bound to the top level.
// Depends on bpfm_pkg.
module bpfm_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input bpfm_pkg::rsp_t m_rsp
);
    import bpfm_pkg::*;

    // hold result while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rsp)) else $error("result changed");
    // one request at a time
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("overlap");
    // accept starts work: no result next cycle
    a_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid && !s_ready) else $error("accept");
    // read and zero fill never together
    a_rz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_rsp.read_valid && m_rsp.zero_fill)) else $error("read and fill");
endmodule

bind buffer_pool_frame_manager bpfm_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_rsp
);
